FILE: hw/rtl/i2cmbc_pkg.sv
// shared types and constants for the i2c master byte controller
// no dependencies
package i2cmbc_pkg;

   localparam int DIVIDER_BITS_DEFAULT = 12;
   localparam int BAUD_RESET = 193;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] FUNC_START   = 3'd0;
   localparam logic [2:0] FUNC_RESTART = 3'd1;
   localparam logic [2:0] FUNC_STOP    = 3'd2;
   localparam logic [2:0] FUNC_WRITE   = 3'd3;
   localparam logic [2:0] FUNC_READ    = 3'd4;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_START   = 8'b0000_0010,
      PH_RESTART = 8'b0000_0100,
      PH_STOP    = 8'b0000_1000,
      PH_WR_LOW  = 8'b0001_0000,
      PH_WR_HIGH = 8'b0010_0000,
      PH_RD_LOW  = 8'b0100_0000,
      PH_RD_HIGH = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] func;
      logic [7:0] tx_data;
      logic       ack_to_send;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_received;
      logic [7:0] rx_data;
      logic       cmd_rejected;
   } result_type;

endpackage

FILE: hw/rtl/i2c_master_byte_controller.sv
// i2c master byte controller: one tick transaction in, one result out
// a tick is registered in the queue, then the sequencer step registers its result for the response port
// throughput: one tick per cycle while the response output is not stalled by rsp_tready
// synchronous active-high reset: idle, lines released, divisor 193
// depends on i2cmbc_pkg, i2cmbc_front, i2cmbc_engine
module i2c_master_byte_controller #(
   parameter int DIVIDER_BITS = i2cmbc_pkg::DIVIDER_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [DIVIDER_BITS-1:0] csr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // cmd_valid, func[3], tx_data[8], ack_to_send, sda_in, zero pad[2]
   input  logic [15:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // scl_low, sda_low, busy_res, done_res, ack_received, rx_data[8], cmd_rejected, pad[2]
   output logic [15:0]             rsp_tdata
);
   import i2cmbc_pkg::*;

   tick_type   in_tick, q_tick;
   result_type res;
   logic       q_valid, q_ready;

   assign csr_ready = 1'b1;
   assign in_tick.cmd_valid   = req_tdata[0];
   assign in_tick.func        = req_tdata[3:1];
   assign in_tick.tx_data     = req_tdata[11:4];
   assign in_tick.ack_to_send = req_tdata[12];
   assign in_tick.sda_in      = req_tdata[13];

   assign rsp_tdata = {2'b00, res.cmd_rejected, res.rx_data, res.ack_received,
                       res.done_res, res.busy_res, res.sda_low, res.scl_low};

   i2cmbc_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_tick,
      .q_valid, .q_ready, .q_tick
   );

   i2cmbc_engine #(.DIVIDER_BITS(DIVIDER_BITS)) u_engine (
      .clock, .reset, .csr_valid, .csr_data, .q_valid, .q_ready, .q_tick,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );
endmodule

FILE: hw/rtl/i2cmbc_front.sv
// front end: accepts tick transactions and queues them
// depends on i2cmbc_pkg
module i2cmbc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  i2cmbc_pkg::tick_type  in_tick,
   output logic                  q_valid,
   input  logic                  q_ready,
   output i2cmbc_pkg::tick_type  q_tick
);
   import i2cmbc_pkg::*;

   tick_type   mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'(QUEUE_DEPTH)) || q_ready;
   assign q_valid  = count_ff != 2'd0;
   assign q_tick   = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

FILE: hw/rtl/i2cmbc_engine.sv
// back end: bus sequencer stepping one tick per queued transaction
// depends on i2cmbc_pkg
module i2cmbc_engine #(
   parameter int DIVIDER_BITS = i2cmbc_pkg::DIVIDER_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [DIVIDER_BITS-1:0] csr_data,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  i2cmbc_pkg::tick_type    q_tick,
   output logic                    out_valid,
   input  logic                    out_ready,
   output i2cmbc_pkg::result_type  out_res
);
   import i2cmbc_pkg::*;

   logic [DIVIDER_BITS-1:0] baud_ff, baud_in;
   phase_type               phase_ff, phase_in;
   logic [3:0]              bit_ff, bit_in;
   logic [DIVIDER_BITS:0]   cnt_ff, cnt_in;
   logic [7:0]              shift_ff, shift_in;
   logic                    ack_ff, ack_in;
   logic [7:0]              rxbuf_ff, rxbuf_in;
   logic                    scl_ff, scl_in, sda_ff, sda_in_d, pend_ff, pend_in;
   logic                    ovalid_ff, ovalid_in;
   result_type              res_ff, res_in;
   logic                    step, done, rej, slot_end, apply;
   logic [7:0]              sh_next;

   assign q_ready   = !ovalid_ff || out_ready;
   assign step      = q_valid && q_ready;
   assign out_valid = ovalid_ff;
   assign out_res   = res_ff;
   assign slot_end  = cnt_ff >= ({1'b0, baud_ff} + 1'b1);
   assign baud_in   = csr_valid ? csr_data : baud_ff;

   always_comb begin
      phase_in = phase_ff; bit_in = bit_ff; cnt_in = cnt_ff;
      shift_in = shift_ff; ack_in = ack_ff; rxbuf_in = rxbuf_ff;
      scl_in = scl_ff; sda_in_d = sda_ff; pend_in = pend_ff;
      done = 1'b0; rej = 1'b0; apply = 1'b0; sh_next = '0;
      if (step) begin
         if (phase_ff != PH_IDLE) begin
            rej = q_tick.cmd_valid;
            if (slot_end) begin
               cnt_in = '0;
               apply = 1'b1;
               unique case (phase_ff)
                  PH_START: begin
                     scl_in = 1'b1; sda_in_d = 1'b1; done = 1'b1;
                  end
                  PH_RESTART: begin
                     if (bit_ff >= 4'd2) begin
                        scl_in = 1'b1; sda_in_d = 1'b1; done = 1'b1;
                     end else begin
                        bit_in = bit_ff + 4'd1;
                     end
                  end
                  PH_STOP: begin
                     if (bit_ff >= 4'd2) done = 1'b1;
                     else bit_in = bit_ff + 4'd1;
                  end
                  PH_WR_LOW: phase_in = PH_WR_HIGH;
                  PH_RD_LOW: phase_in = PH_RD_HIGH;
                  PH_WR_HIGH: begin
                     if (bit_ff >= 4'd8) begin
                        ack_in = q_tick.sda_in; scl_in = 1'b1; sda_in_d = 1'b0;
                        done = 1'b1;
                     end else begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in = bit_ff + 4'd1; phase_in = PH_WR_LOW;
                     end
                  end
                  PH_RD_HIGH: begin
                     if (bit_ff >= 4'd8) begin
                        scl_in = 1'b1; sda_in_d = 1'b0; done = 1'b1;
                     end else begin
                        sh_next = {shift_ff[6:0], q_tick.sda_in};
                        shift_in = sh_next;
                        if (bit_ff == 4'd7) rxbuf_in = sh_next;
                        bit_in = bit_ff + 4'd1; phase_in = PH_RD_LOW;
                     end
                  end
                  default: done = 1'b1;
               endcase
               if (done) begin
                  phase_in = PH_IDLE; bit_in = '0; apply = 1'b0;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end else if (q_tick.cmd_valid && q_tick.func <= FUNC_READ) begin
            bit_in = '0; cnt_in = '0; apply = 1'b1;
            unique case (q_tick.func)
               FUNC_START:   phase_in = PH_START;
               FUNC_RESTART: phase_in = PH_RESTART;
               FUNC_STOP:    phase_in = PH_STOP;
               FUNC_WRITE: begin
                  phase_in = PH_WR_LOW; shift_in = q_tick.tx_data;
               end
               default: begin
                  phase_in = PH_RD_LOW; shift_in = '0; pend_in = q_tick.ack_to_send;
               end
            endcase
         end
         if (apply) begin
            unique case (phase_in)
               PH_START: begin scl_in = 1'b0; sda_in_d = 1'b1; end
               PH_RESTART: begin
                  if (bit_in == 4'd0) begin scl_in = 1'b1; sda_in_d = 1'b0; end
                  else if (bit_in == 4'd1) begin scl_in = 1'b0; sda_in_d = 1'b0; end
                  else begin scl_in = 1'b0; sda_in_d = 1'b1; end
               end
               PH_STOP: begin
                  if (bit_in == 4'd0) begin scl_in = 1'b1; sda_in_d = 1'b1; end
                  else if (bit_in == 4'd1) begin scl_in = 1'b0; sda_in_d = 1'b1; end
                  else begin scl_in = 1'b0; sda_in_d = 1'b0; end
               end
               PH_WR_LOW: begin
                  scl_in = 1'b1;
                  sda_in_d = (bit_in < 4'd8) ? ~shift_in[7] : 1'b0;
               end
               PH_RD_LOW: begin
                  scl_in = 1'b1;
                  sda_in_d = (bit_in < 4'd8) ? 1'b0 : ~pend_in;
               end
               PH_WR_HIGH, PH_RD_HIGH: scl_in = 1'b0;
               default: ;
            endcase
         end
      end
      res_in.scl_low      = scl_in;
      res_in.sda_low      = sda_in_d;
      res_in.busy_res     = phase_in != PH_IDLE;
      res_in.done_res     = done;
      res_in.ack_received = ack_in;
      res_in.rx_data      = rxbuf_in;
      res_in.cmd_rejected = rej;
      ovalid_in = step ? 1'b1 : (ovalid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (step) res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_ff <= DIVIDER_BITS'(BAUD_RESET);
         phase_ff <= PH_IDLE; bit_ff <= '0; cnt_ff <= '0; shift_ff <= '0;
         ack_ff <= 1'b0; rxbuf_ff <= '0; scl_ff <= 1'b0; sda_ff <= 1'b0;
         pend_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         baud_ff <= baud_in;
         phase_ff <= phase_in; bit_ff <= bit_in; cnt_ff <= cnt_in;
         shift_ff <= shift_in; ack_ff <= ack_in; rxbuf_ff <= rxbuf_in;
         scl_ff <= scl_in; sda_ff <= sda_in_d; pend_ff <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end
endmodule

FILE: hw/rtl/i2cmbc_checker.sv
// port-level checks for the i2c master byte controller
// depends on i2c_master_byte_controller
module i2cmbc_props (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2]) else $error("done while busy");
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[2] || rsp_tdata[3])
      else $error("reject when idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:14] == 2'b00) else $error("padding set");
endmodule

bind i2c_master_byte_controller i2cmbc_props u_props (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
